@@ hw/rtl/smm_pkg.sv @@
// ============================================================================
// smm_pkg
// Shared types and constants for the modulation matrix.
// ============================================================================
package smm_pkg;

    // Number of slot registers that the configuration port holds.
    localparam int MAX_SLOTS = 4;

    // Accumulator width: products are Q.26 and the worst-case sum of the
    // fixed routes and four slots stays well inside 34 signed bits.
    localparam int ACC_W   = 34;
    localparam int FRAC_W  = 13;
    localparam int OUT_W   = 24;
    localparam int DEST_N  = 4;

    localparam int OUT_MAX = 8388607;
    localparam int OUT_MIN = -8388608;

    // Fixed-route gains in units of 1/8192.
    localparam int K_ONE = 8192;
    localparam int K_005 = 410;
    localparam int K_010 = 819;
    localparam int K_025 = 2048;
    localparam int K_050 = 4096;
    localparam int ROUND_HALF = 4096;

    // Configuration register indexes.
    localparam logic [3:0] CFG_ROUTE_FIRST = 4'd0;
    localparam logic [3:0] CFG_DEPTH_FIRST = 4'd4;
    localparam logic [3:0] CFG_COUNT       = 4'd8;

    // Source codes. The last one selects a constant zero.
    localparam logic [2:0] SRC_VELOCITY   = 3'd0;
    localparam logic [2:0] SRC_PITCH_ENV  = 3'd1;
    localparam logic [2:0] SRC_FILTER_ENV = 3'd2;
    localparam logic [2:0] SRC_AMP_ENV    = 3'd3;
    localparam logic [2:0] SRC_LFO_FIRST  = 3'd4;
    localparam logic [2:0] SRC_LFO_SECOND = 3'd5;
    localparam logic [2:0] SRC_AFTERTOUCH = 3'd6;
    localparam logic [2:0] SRC_ZERO       = 3'd7;

    // Destination codes, which are also the accumulator lane numbers.
    localparam logic [1:0] DEST_PITCH  = 2'd0;
    localparam logic [1:0] DEST_CUTOFF = 2'd1;
    localparam logic [1:0] DEST_AMP    = 2'd2;
    localparam logic [1:0] DEST_PAN    = 2'd3;

    typedef struct packed {
        logic signed [15:0] note_velocity;
        logic signed [15:0] pitch_envelope;
        logic signed [15:0] filter_envelope;
        logic signed [15:0] amp_envelope;
        logic signed [15:0] lfo_first;
        logic signed [15:0] lfo_second;
        logic signed [15:0] after_touch;
    } smm_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] pitch_amount;
        logic signed [OUT_W-1:0] cutoff_amount;
        logic signed [OUT_W-1:0] amp_amount;
        logic signed [OUT_W-1:0] pan_amount;
    } smm_out_t;

    typedef struct packed {
        logic       enable;
        logic [2:0] source;
        logic [1:0] dest;
    } smm_route_t;

    // What travels from one cell to the next: the sources and the four
    // running sums.
    typedef struct packed {
        smm_in_t                      src;
        logic [DEST_N-1:0][ACC_W-1:0] acc;
    } smm_stage_t;

    function automatic logic signed [15:0] src_select(smm_in_t s, logic [2:0] code);
        logic signed [15:0] v;
        v = '0;
        case (code)
            SRC_VELOCITY:   v = s.note_velocity;
            SRC_PITCH_ENV:  v = s.pitch_envelope;
            SRC_FILTER_ENV: v = s.filter_envelope;
            SRC_AMP_ENV:    v = s.amp_envelope;
            SRC_LFO_FIRST:  v = s.lfo_first;
            SRC_LFO_SECOND: v = s.lfo_second;
            SRC_AFTERTOUCH: v = s.after_touch;
            default:        v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/synth_modulation_matrix.sv @@
// ============================================================================
// synth_modulation_matrix
// Modulation matrix: seven sources in, four saturated destination sums out.
// ============================================================================
//
//  Channel   Signals                          Carries
//  -------   -------------------------------  ---------------------------------
//  mod       mod_valid, mod_stall, mod_data   one request of seven Q2.13 sources
//  amt       amt_valid, amt_stall, amt_data   four Q10.13 destination amounts
//  cfg       cfg_we, cfg_index, cfg_data      slot route and depth writes
//
//  One request is taken every cycle while mod_stall is low. Each request
//  passes through the chain: the fixed-route cell, each slot cell and the
//  rounding stage, each of which holds a single register stage. Reset
//  clears the valid flags of every stage and all slot registers. A stall
//  on the amt side holds every full stage back to the first empty one
//  within the same cycle, so empty stages further up still take new
//  requests until the chain is full, at which point mod_stall rises
//  together with amt_stall.
//
module synth_modulation_matrix
#(
    parameter int SLOT_COUNT = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              mod_valid,
    output logic              mod_stall,
    input  smm_pkg::smm_in_t  mod_data,
    output logic              amt_valid,
    input  logic              amt_stall,
    output smm_pkg::smm_out_t amt_data,
    input  logic              cfg_we,
    input  logic [3:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    // Slot registers. All four are kept even when fewer slot cells are
    // built; the surplus ones are simply never read by a cell.
    logic [smm_pkg::MAX_SLOTS-1:0][5:0]  route_reg;
    logic [smm_pkg::MAX_SLOTS-1:0][15:0] depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_reg <= '0;
            depth_reg <= '0;
        end
        else if (cfg_we)
        begin
            // Writes to indexes past the list are dropped.
            if (cfg_index < smm_pkg::CFG_DEPTH_FIRST)
                route_reg[cfg_index[1:0]] <= cfg_data[5:0];
            else if (cfg_index < smm_pkg::CFG_COUNT)
                depth_reg[cfg_index[1:0]] <= cfg_data;
        end
    end

    // The chain: element k is the output of the stage in front of slot k,
    // and stall_chain[k] is the hold that stage sees from behind it.
    logic                chain_valid [SLOT_COUNT+1];
    logic                stall_chain [SLOT_COUNT+1];
    smm_pkg::smm_stage_t chain_data  [SLOT_COUNT+1];

    smm_fixed_cell u_fixed
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (mod_valid),
        .up_stall   (mod_stall),
        .up_data    (mod_data),
        .down_valid (chain_valid[0]),
        .down_stall (stall_chain[0]),
        .down_data  (chain_data[0])
    );

    for (genvar k = 0; k < SLOT_COUNT; k++)
    begin : g_slot
        smm_slot_cell u_slot
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .route      (smm_pkg::smm_route_t'(route_reg[k])),
            .depth      ($signed(depth_reg[k])),
            .up_valid   (chain_valid[k]),
            .up_stall   (stall_chain[k]),
            .up_data    (chain_data[k]),
            .down_valid (chain_valid[k+1]),
            .down_stall (stall_chain[k+1]),
            .down_data  (chain_data[k+1])
        );
    end

    smm_output_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (chain_valid[SLOT_COUNT]),
        .up_stall   (stall_chain[SLOT_COUNT]),
        .up_data    (chain_data[SLOT_COUNT]),
        .down_valid (amt_valid),
        .down_stall (amt_stall),
        .down_data  (amt_data)
    );

    // The input side can only be held when a finished result is waiting.
    a_stall_needs_result : assert property (@(posedge clk) disable iff (!rst_n)
        mod_stall |-> (amt_valid && amt_stall))
        else $error("input held while no result is waiting");

    // A write to the first route register lands with its low six bits.
    a_route_write : assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (cfg_index == smm_pkg::CFG_ROUTE_FIRST))
        |=> (route_reg[0] == $past(cfg_data[5:0])))
        else $error("route write not taken");

    // Writes beyond the register list change nothing.
    a_stray_write : assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (cfg_index >= smm_pkg::CFG_COUNT))
        |=> ($stable(route_reg) && $stable(depth_reg)))
        else $error("out-of-range write altered a slot register");

endmodule

@@ hw/rtl/smm_fixed_cell.sv @@
// ============================================================================
// smm_fixed_cell
// Head of the chain: forms the fixed routes and opens the four sums.
// ============================================================================
module smm_fixed_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_stall,
    input  smm_pkg::smm_in_t    up_data,
    output logic                down_valid,
    input  logic                down_stall,
    output smm_pkg::smm_stage_t down_data
);

    logic                valid_reg;
    smm_pkg::smm_stage_t data_reg;
    smm_pkg::smm_stage_t data_next;

    logic signed [14:0]               vel_clamped;
    logic signed [30:0]               amp_product;
    logic signed [smm_pkg::ACC_W-1:0] sum_pitch;
    logic signed [smm_pkg::ACC_W-1:0] sum_cutoff;
    logic signed [smm_pkg::ACC_W-1:0] sum_amp;
    logic signed [smm_pkg::ACC_W-1:0] sum_pan;

    // Velocity is held to 0..1.0 for the amp route only.
    always_comb
    begin
        if (up_data.note_velocity < 0)
            vel_clamped = '0;
        else if (up_data.note_velocity > 16'(smm_pkg::K_ONE))
            vel_clamped = 15'(smm_pkg::K_ONE);
        else
            vel_clamped = up_data.note_velocity[14:0];
    end

    assign amp_product = up_data.amp_envelope * vel_clamped;

    always_comb
    begin
        sum_pitch  = smm_pkg::ACC_W'(up_data.pitch_envelope) * smm_pkg::ACC_W'(smm_pkg::K_ONE)
                   + smm_pkg::ACC_W'(up_data.lfo_first) * smm_pkg::ACC_W'(smm_pkg::K_005);
        sum_cutoff = smm_pkg::ACC_W'(up_data.filter_envelope) * smm_pkg::ACC_W'(smm_pkg::K_ONE)
                   + smm_pkg::ACC_W'(up_data.note_velocity) * smm_pkg::ACC_W'(smm_pkg::K_025)
                   + smm_pkg::ACC_W'(up_data.lfo_first) * smm_pkg::ACC_W'(smm_pkg::K_010);
        sum_amp    = smm_pkg::ACC_W'(amp_product)
                   + smm_pkg::ACC_W'(up_data.lfo_second) * smm_pkg::ACC_W'(smm_pkg::K_005);
        sum_pan    = smm_pkg::ACC_W'(up_data.lfo_second) * smm_pkg::ACC_W'(smm_pkg::K_050);

        data_next.src                       = up_data;
        data_next.acc[smm_pkg::DEST_PITCH]  = sum_pitch;
        data_next.acc[smm_pkg::DEST_CUTOFF] = sum_cutoff;
        data_next.acc[smm_pkg::DEST_AMP]    = sum_amp;
        data_next.acc[smm_pkg::DEST_PAN]    = sum_pan;
    end

    assign up_stall = valid_reg && down_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!up_stall)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
            data_reg <= data_next;
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule

@@ hw/rtl/smm_slot_cell.sv @@
// ============================================================================
// smm_slot_cell
// One user slot: adds source times depth onto the routed sum when enabled.
// ============================================================================
module smm_slot_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  smm_pkg::smm_route_t  route,
    input  logic signed [15:0]   depth,
    input  logic                 up_valid,
    output logic                 up_stall,
    input  smm_pkg::smm_stage_t  up_data,
    output logic                 down_valid,
    input  logic                 down_stall,
    output smm_pkg::smm_stage_t  down_data
);

    logic                valid_reg;
    smm_pkg::smm_stage_t data_reg;
    smm_pkg::smm_stage_t data_next;
    logic signed [15:0]  picked;
    logic signed [31:0]  product;

    assign picked  = smm_pkg::src_select(up_data.src, route.source);
    assign product = picked * depth;

    always_comb
    begin
        data_next = up_data;
        if (route.enable)
            data_next.acc[route.dest] = up_data.acc[route.dest]
                                      + smm_pkg::ACC_W'(product);
    end

    assign up_stall = valid_reg && down_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!up_stall)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
            data_reg <= data_next;
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule

@@ hw/rtl/smm_output_stage.sv @@
// ============================================================================
// smm_output_stage
// Tail of the chain: rounds each sum to Q.13, saturates and holds the result.
// ============================================================================
module smm_output_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_stall,
    input  smm_pkg::smm_stage_t up_data,
    output logic                down_valid,
    input  logic                down_stall,
    output smm_pkg::smm_out_t   down_data
);

    logic                                         valid_reg;
    smm_pkg::smm_out_t                            data_reg;
    logic [smm_pkg::DEST_N-1:0][smm_pkg::OUT_W-1:0] lane_out;

    // Round to nearest with ties upward, then clip to 24 signed bits.
    always_comb
    begin
        for (int i = 0; i < smm_pkg::DEST_N; i++)
        begin
            logic signed [smm_pkg::ACC_W-1:0] rounded;
            logic signed [smm_pkg::ACC_W-1:0] scaled;
            rounded = $signed(up_data.acc[i]) + smm_pkg::ACC_W'(smm_pkg::ROUND_HALF);
            scaled  = rounded >>> smm_pkg::FRAC_W;
            if (scaled > smm_pkg::ACC_W'(smm_pkg::OUT_MAX))
                lane_out[i] = smm_pkg::OUT_W'(smm_pkg::OUT_MAX);
            else if (scaled < smm_pkg::ACC_W'(smm_pkg::OUT_MIN))
                lane_out[i] = smm_pkg::OUT_W'(smm_pkg::OUT_MIN);
            else
                lane_out[i] = scaled[smm_pkg::OUT_W-1:0];
        end
    end

    assign up_stall = valid_reg && down_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!up_stall)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            data_reg.pitch_amount  <= lane_out[smm_pkg::DEST_PITCH];
            data_reg.cutoff_amount <= lane_out[smm_pkg::DEST_CUTOFF];
            data_reg.amp_amount    <= lane_out[smm_pkg::DEST_AMP];
            data_reg.pan_amount    <= lane_out[smm_pkg::DEST_PAN];
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule

@@ tb/smm_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_tb_pkg
// Scoreboard for the modulation matrix. It keeps its own copy of the slot
// registers, works out the four destination amounts of every accepted request
// and compares them in order with what the block returns.
// ----------------------------------------------------------------------------
package smm_tb_pkg;

    class modulation_scoreboard;

        logic        [5:0]     slot_route [smm_pkg::MAX_SLOTS];
        logic signed [15:0]    slot_depth [smm_pkg::MAX_SLOTS];
        int                    active_slots;
        smm_pkg::smm_out_t     expected_amounts [$];
        int                    failures;

        function new(int slots);
            for (int i = 0; i < smm_pkg::MAX_SLOTS; i++)
            begin
                slot_route[i] = '0;
                slot_depth[i] = '0;
            end
            active_slots = slots;
            failures     = 0;
        endfunction

        // Mirrors one register write; indexes past the last register are dropped.
        function void write_register(logic [3:0] index, logic [15:0] data);
            if (index < smm_pkg::CFG_DEPTH_FIRST)
                slot_route[index - smm_pkg::CFG_ROUTE_FIRST] = data[5:0];
            else if (index < smm_pkg::CFG_COUNT)
                slot_depth[index - smm_pkg::CFG_DEPTH_FIRST] = data;
        endfunction

        function longint source_level(smm_pkg::smm_in_t s, logic [2:0] code);
            longint v;
            case (code)
                smm_pkg::SRC_VELOCITY:   v = longint'($signed(s.note_velocity));
                smm_pkg::SRC_PITCH_ENV:  v = longint'($signed(s.pitch_envelope));
                smm_pkg::SRC_FILTER_ENV: v = longint'($signed(s.filter_envelope));
                smm_pkg::SRC_AMP_ENV:    v = longint'($signed(s.amp_envelope));
                smm_pkg::SRC_LFO_FIRST:  v = longint'($signed(s.lfo_first));
                smm_pkg::SRC_LFO_SECOND: v = longint'($signed(s.lfo_second));
                smm_pkg::SRC_AFTERTOUCH: v = longint'($signed(s.after_touch));
                default:                 v = 0;
            endcase
            return v;
        endfunction

        // Round half up to Q.13, then clip to the signed 24-bit range.
        function logic [smm_pkg::OUT_W-1:0] round_and_clip(longint sum26);
            longint r;
            r = (sum26 + smm_pkg::ROUND_HALF) >>> smm_pkg::FRAC_W;
            if (r > smm_pkg::OUT_MAX)
                r = smm_pkg::OUT_MAX;
            if (r < smm_pkg::OUT_MIN)
                r = smm_pkg::OUT_MIN;
            return r[smm_pkg::OUT_W-1:0];
        endfunction

        function smm_pkg::smm_out_t predict_amounts(smm_pkg::smm_in_t s);
            longint            sum [smm_pkg::DEST_N];
            longint            vel_gain;
            smm_pkg::smm_out_t amounts;
            logic [5:0]        r;
            vel_gain = source_level(s, smm_pkg::SRC_VELOCITY);
            if (vel_gain < 0)
                vel_gain = 0;
            if (vel_gain > smm_pkg::K_ONE)
                vel_gain = smm_pkg::K_ONE;
            sum[smm_pkg::DEST_PITCH]  = source_level(s, smm_pkg::SRC_PITCH_ENV) * smm_pkg::K_ONE
                                      + source_level(s, smm_pkg::SRC_LFO_FIRST) * smm_pkg::K_005;
            sum[smm_pkg::DEST_CUTOFF] = source_level(s, smm_pkg::SRC_FILTER_ENV) * smm_pkg::K_ONE
                                      + source_level(s, smm_pkg::SRC_VELOCITY) * smm_pkg::K_025
                                      + source_level(s, smm_pkg::SRC_LFO_FIRST) * smm_pkg::K_010;
            sum[smm_pkg::DEST_AMP]    = source_level(s, smm_pkg::SRC_AMP_ENV) * vel_gain
                                      + source_level(s, smm_pkg::SRC_LFO_SECOND) * smm_pkg::K_005;
            sum[smm_pkg::DEST_PAN]    = source_level(s, smm_pkg::SRC_LFO_SECOND) * smm_pkg::K_050;
            for (int i = 0; i < active_slots && i < smm_pkg::MAX_SLOTS; i++)
            begin
                r = slot_route[i];
                if (r[5])
                    sum[r[1:0]] += source_level(s, r[4:2]) * longint'(slot_depth[i]);
            end
            amounts.pitch_amount  = round_and_clip(sum[smm_pkg::DEST_PITCH]);
            amounts.cutoff_amount = round_and_clip(sum[smm_pkg::DEST_CUTOFF]);
            amounts.amp_amount    = round_and_clip(sum[smm_pkg::DEST_AMP]);
            amounts.pan_amount    = round_and_clip(sum[smm_pkg::DEST_PAN]);
            return amounts;
        endfunction

        function void note_request(smm_pkg::smm_in_t s);
            expected_amounts.push_back(predict_amounts(s));
        endfunction

        function void compare_field(string label, logic [smm_pkg::OUT_W-1:0] want,
                                    logic [smm_pkg::OUT_W-1:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, label,
                         $signed(want), $signed(got));
                failures++;
            end
        endfunction

        function void check_amounts(smm_pkg::smm_out_t got);
            smm_pkg::smm_out_t want;
            if (expected_amounts.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                failures++;
                return;
            end
            want = expected_amounts.pop_front();
            compare_field("pitch_amount",  want.pitch_amount,  got.pitch_amount);
            compare_field("cutoff_amount", want.cutoff_amount, got.cutoff_amount);
            compare_field("amp_amount",    want.amp_amount,    got.amp_amount);
            compare_field("pan_amount",    want.pan_amount,    got.pan_amount);
        endfunction

        function int pending();
            return expected_amounts.size();
        endfunction

    endclass

endpackage

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for synth_modulation_matrix. A short directed part walks
// the field extremes, the velocity clamp, rounding ties, the zero source and
// every route; random slot settings and random source sets follow, with
// random idling on both channels. Results are checked in order by a scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SLOT_COUNT   = 4;
    // Slot cells plus the fixed-route cell and the rounding stage, with margin.
    localparam int SETTLE       = SLOT_COUNT + 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 100;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              mod_valid = 1'b0;
    logic              mod_stall;
    smm_pkg::smm_in_t  mod_data  = '0;
    logic              amt_valid;
    logic              amt_stall = 1'b0;
    smm_pkg::smm_out_t amt_data;
    logic              cfg_we    = 1'b0;
    logic [3:0]        cfg_index = '0;
    logic [15:0]       cfg_data  = '0;

    smm_tb_pkg::modulation_scoreboard sb;

    // Idling controls: a rate of zero means no idling at all, otherwise an
    // idle burst starts on one try in that many (per request or stall-free cycle).
    int gap_rate   = 0;
    int stall_rate = 0;
    int stall_left = 0;
    int cycle_count = 0;

    // Settings that apply_setting writes into the block.
    logic [5:0]  new_route [smm_pkg::MAX_SLOTS];
    logic [15:0] new_depth [smm_pkg::MAX_SLOTS];

    synth_modulation_matrix #(.SLOT_COUNT(SLOT_COUNT)) uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .mod_valid (mod_valid),
        .mod_stall (mod_stall),
        .mod_data  (mod_data),
        .amt_valid (amt_valid),
        .amt_stall (amt_stall),
        .amt_data  (amt_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Everything is sampled at the rising edge, before the nonblocking
    // updates of that edge land, so the values seen are those the block saw.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_register(cfg_index, cfg_data);
            if (mod_valid && !mod_stall)
                sb.note_request(mod_data);
            if (amt_valid && !amt_stall)
                sb.check_amounts(amt_data);
        end
    end

    // Receiver side: random stall bursts of random length.
    always @(posedge clk)
    begin
        if (stall_left == 0 && stall_rate != 0 && $urandom_range(1, stall_rate) == 1)
            stall_left = $urandom_range(1, 11);
        amt_stall <= (stall_left != 0);
        if (stall_left != 0)
            stall_left = stall_left - 1;
    end

    // The run is cut off well beyond the slowest correct run.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // A level biased towards the extremes, zero and the small values around
    // it, and the 0..1 band where the velocity clamp does nothing.
    function automatic logic [15:0] random_level();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'h7FFF;
            1:       v = 16'h8000;
            2:       v = 16'h0000;
            3:       v = 16'($urandom_range(0, 32)) - 16'd16;
            4:       v = 16'($urandom_range(0, smm_pkg::K_ONE));
            default: v = 16'($urandom());
        endcase
        return v;
    endfunction

    function automatic smm_pkg::smm_in_t random_sources();
        smm_pkg::smm_in_t s;
        s.note_velocity   = random_level();
        s.pitch_envelope  = random_level();
        s.filter_envelope = random_level();
        s.amp_envelope    = random_level();
        s.lfo_first       = random_level();
        s.lfo_second      = random_level();
        s.after_touch     = random_level();
        return s;
    endfunction

    function automatic smm_pkg::smm_in_t make_sources(logic [15:0] vel, logic [15:0] penv,
                                                      logic [15:0] fenv, logic [15:0] aenv,
                                                      logic [15:0] lfo1, logic [15:0] lfo2,
                                                      logic [15:0] touch);
        smm_pkg::smm_in_t s;
        s.note_velocity   = vel;
        s.pitch_envelope  = penv;
        s.filter_envelope = fenv;
        s.amp_envelope    = aenv;
        s.lfo_first       = lfo1;
        s.lfo_second      = lfo2;
        s.after_touch     = touch;
        return s;
    endfunction

    // Offers one request and returns at the edge where it is taken. Valid is
    // left high so that back-to-back requests need no second assignment.
    task automatic send_request(smm_pkg::smm_in_t s);
        int gap;
        gap = 0;
        if (gap_rate != 0 && $urandom_range(1, gap_rate) == 1)
            gap = $urandom_range(1, 11);
        if (gap != 0)
        begin
            // The payload is junk while valid is low; the block must ignore it.
            mod_valid <= 1'b0;
            mod_data  <= random_sources();
            repeat (gap) @(posedge clk);
        end
        mod_valid <= 1'b1;
        mod_data  <= s;
        do
            @(posedge clk);
        while (mod_stall);
    endtask

    // Lowers valid and waits until every result is back and the chain is empty.
    // The first edge lets the scoreboard note the last accepted request.
    task automatic drain();
        mod_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(logic [3:0] index, logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Writes all eight slot registers and one index past the end. With
    // junk_high set, the unused upper bits of the route writes carry noise.
    task automatic apply_setting(bit junk_high);
        logic [15:0] word;
        for (int i = 0; i < smm_pkg::MAX_SLOTS; i++)
        begin
            word = junk_high ? 16'($urandom()) : 16'h0000;
            word[5:0] = new_route[i];
            write_register(smm_pkg::CFG_ROUTE_FIRST + 4'(i), word);
        end
        for (int i = 0; i < smm_pkg::MAX_SLOTS; i++)
            write_register(smm_pkg::CFG_DEPTH_FIRST + 4'(i), new_depth[i]);
        write_register(4'($urandom_range(smm_pkg::CFG_COUNT, 15)), 16'($urandom()));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_slot(int slot, logic enable, logic [2:0] source,
                            logic [1:0] dest, logic [15:0] depth);
        new_route[slot] = {enable, source, dest};
        new_depth[slot] = depth;
    endtask

    initial
    begin
        sb = new(SLOT_COUNT);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first with the slots as reset left them: only the
        // fixed routes act. Covers the field extremes, the velocity clamp at
        // both ends and just past one, and the rounding ties on the pan route.
        gap_rate   = 4;
        stall_rate = 4;
        send_request(make_sources(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                  16'h0000, 16'h0000, 16'h0000));
        send_request(make_sources(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                  16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_request(make_sources(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                  16'h8000, 16'h8000, 16'h8000));
        send_request(make_sources(16'hFFFF, 16'h0100, 16'h0200, 16'h7FFF,
                                  16'h0011, 16'h0001, 16'h0000));
        send_request(make_sources(16'd9000, 16'h0000, 16'h0000, 16'h8000,
                                  16'h0000, 16'hFFFF, 16'h0000));
        send_request(make_sources(16'd8192, 16'hF000, 16'h1234, 16'h4000,
                                  16'hFFFF, 16'h0003, 16'h0000));
        send_request(make_sources(16'd8193, 16'h0001, 16'hFFFF, 16'h7FFF,
                                  16'h0001, 16'hFFFD, 16'h0000));
        send_request(make_sources(16'd4096, 16'h0000, 16'h0000, 16'hFFFF,
                                  16'h8000, 16'h7FFF, 16'h7FFF));
        drain();

        // Slots on every destination, including a slot fed by the zero source
        // and depths at both extremes.
        set_slot(0, 1'b1, smm_pkg::SRC_VELOCITY,   smm_pkg::DEST_PITCH,  16'h7FFF);
        set_slot(1, 1'b1, smm_pkg::SRC_ZERO,       smm_pkg::DEST_CUTOFF, 16'h8000);
        set_slot(2, 1'b1, smm_pkg::SRC_AFTERTOUCH, smm_pkg::DEST_AMP,    16'h8000);
        set_slot(3, 1'b1, smm_pkg::SRC_LFO_FIRST,  smm_pkg::DEST_PAN,    16'h7FFF);
        apply_setting(1'b0);
        send_request(make_sources(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                  16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_request(make_sources(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                  16'h8000, 16'h8000, 16'h8000));
        send_request(make_sources(16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                                  16'h8000, 16'h0000, 16'h7FFF));
        send_request(make_sources(16'd8192, 16'h1000, 16'hE000, 16'h2000,
                                  16'h0001, 16'hFFFF, 16'h8000));
        drain();

        // The remaining sources, each onto a different lane.
        set_slot(0, 1'b1, smm_pkg::SRC_PITCH_ENV,  smm_pkg::DEST_CUTOFF, 16'h7FFF);
        set_slot(1, 1'b1, smm_pkg::SRC_FILTER_ENV, smm_pkg::DEST_AMP,    16'h8000);
        set_slot(2, 1'b1, smm_pkg::SRC_AMP_ENV,    smm_pkg::DEST_PITCH,  16'h7FFF);
        set_slot(3, 1'b1, smm_pkg::SRC_LFO_SECOND, smm_pkg::DEST_PAN,    16'h8000);
        apply_setting(1'b1);
        send_request(make_sources(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                  16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_request(make_sources(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                  16'h8000, 16'h8000, 16'h8000));
        send_request(make_sources(16'h0000, 16'h8000, 16'h7FFF, 16'h8000,
                                  16'h7FFF, 16'h8000, 16'h7FFF));
        send_request(make_sources(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001,
                                  16'hFFFF, 16'h0001, 16'hFFFF));
        drain();

        // Disabled slots with live depths must add nothing; the first route
        // has every bit but the enable set.
        set_slot(0, 1'b0, smm_pkg::SRC_ZERO,       smm_pkg::DEST_PAN,    16'h7FFF);
        set_slot(1, 1'b0, smm_pkg::SRC_VELOCITY,   smm_pkg::DEST_PITCH,  16'h8000);
        set_slot(2, 1'b0, smm_pkg::SRC_LFO_FIRST,  smm_pkg::DEST_AMP,    16'h1234);
        set_slot(3, 1'b0, smm_pkg::SRC_AFTERTOUCH, smm_pkg::DEST_CUTOFF, 16'hC000);
        apply_setting(1'b1);
        send_request(make_sources(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                  16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_request(make_sources(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                  16'h8000, 16'h8000, 16'h8000));
        drain();

        // Random part: a fresh slot setting per phase, mostly enabled slots,
        // and idling that varies from phase to phase. The last phase runs
        // with no idling on either side.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            for (int i = 0; i < smm_pkg::MAX_SLOTS; i++)
            begin
                new_route[i] = 6'($urandom_range(0, 63));
                if ($urandom_range(0, 3) != 0)
                    new_route[i][5] = 1'b1;
                new_depth[i] = random_level();
            end
            apply_setting($urandom_range(0, 1) == 1);
            if (phase == RANDOM_PHASES - 1)
            begin
                gap_rate   = 0;
                stall_rate = 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       gap_rate = 0;
                    1:       gap_rate = 3;
                    default: gap_rate = 8;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_rate = 0;
                    1:       stall_rate = 3;
                    default: stall_rate = 8;
                endcase
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(random_sources());
            drain();
        end

        if (sb.failures == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ synth_modulation_matrix.f @@
hw/rtl/smm_pkg.sv
hw/rtl/smm_fixed_cell.sv
hw/rtl/smm_slot_cell.sv
hw/rtl/smm_output_stage.sv
hw/rtl/synth_modulation_matrix.sv
tb/smm_tb_pkg.sv
tb/tb_top.sv
